/* hdl/wvb_pkg.sv */
package wvb_pkg;

  // Input transaction: two CT samples and their affection values
  typedef struct packed {
    logic [15:0] ct_ref;
    logic [15:0] aff_ref;
    logic [15:0] ct_tar;
    logic [15:0] aff_tar;
  } in_t;

  // Output transaction: blended value and colormap color
  typedef struct packed {
    logic [15:0] blend_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_t;

  localparam logic [15:0] SAT_CENTER_RESET = 16'd12000;
  localparam longint unsigned K_Q31   = 64'd322123;
  localparam longint unsigned ONE_Q31 = 64'd1 << 31;

  // Unsigned 64-bit quotient by shift and subtract, for elaboration-time tables
  function automatic longint unsigned udiv_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16z) in Q31: floored Taylor sum of e^(-z), then squared four times
  function automatic longint unsigned exp_neg_q31(longint unsigned z);
    longint unsigned term;
    longint unsigned sum;
    term = ONE_Q31;
    sum  = ONE_Q31;
    for (longint unsigned k = 1; k <= 12; k++) begin
      term = udiv_u64((term * z) >> 31, k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int n = 0; n < 4; n++) begin
      sum = (sum * sum) >> 31;
    end
    return sum;
  endfunction

endpackage

/* hdl/weighted_volume_blend_colormap_unit.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | wvb_pkg::in_t  (ct_ref, aff_ref, ct_tar, aff_tar)
// out     | output    | out_valid / out_stall| wvb_pkg::out_t (blend_value, red, green, blue)
// cfg     | input     | cfg_valid / cfg_ready| cfg_data = sat_center
//
// One transaction enters per cycle while in_stall is low. Registered in order: stage 1, the divider entry,
// two restoring dividers resolving one quotient bit per active pipeline stage, color stages 1 and 2.
// Synchronous reset clears all valid bits and loads sat_center with 12000.
// The whole pipeline holds while the output register is full and stalled; nothing is lost.
// cfg_ready is always high; a write applies to transactions accepted after it.
module weighted_volume_blend_colormap_unit #(
  parameter int SAT_TABLE_BITS = 8,
  parameter int FRAC_BITS      = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  wvb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wvb_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  localparam int SAT_DEPTH = 1 << SAT_TABLE_BITS;
  localparam int HQ        = FRAC_BITS + 3;
  localparam int NSTEP     = (HQ > 16) ? HQ : 16;
  localparam int BOFF      = NSTEP - 16;
  localparam int HOFF      = NSTEP - HQ;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;

  typedef logic [FRAC_BITS-1:0] sat_tab_t [SAT_DEPTH];

  // Logistic saturation per table bin, evaluated at the bin center
  function automatic sat_tab_t build_sat();
    sat_tab_t        t;
    longint          c;
    longint unsigned a;
    longint unsigned e;
    longint unsigned v;
    longint unsigned onev;
    int              sh;
    sh   = 18 - SAT_TABLE_BITS;
    onev = 64'd1 << FRAC_BITS;
    for (int i = 0; i < SAT_DEPTH; i++) begin
      c = (longint'(i) << sh) + (longint'(1) << (sh - 1)) - 131072;
      a = (c < 0) ? longint'(-c) : longint'(c);
      e = wvb_pkg::exp_neg_q31((a * wvb_pkg::K_Q31) >> 5);
      if (c >= 0) begin
        v = wvb_pkg::udiv_u64(onev << 31, wvb_pkg::ONE_Q31 + e);
      end else begin
        v = wvb_pkg::udiv_u64(onev * e, wvb_pkg::ONE_Q31 + e);
      end
      if (v > onev - 1) begin
        v = onev - 1;
      end
      t[i] = v[FRAC_BITS-1:0];
    end
    return t;
  endfunction

  localparam sat_tab_t SAT_TAB = build_sat();

  // 255 * c >> FRAC_BITS
  function automatic logic [7:0] to_chan(logic [FRAC_BITS:0] c);
    logic [FRAC_BITS+8:0] t;
    t = {c, 8'd0} - {8'd0, c};
    return t[FRAC_BITS+7:FRAC_BITS];
  endfunction

  logic        adv;
  logic [15:0] sat_center;

  // Hold the whole pipeline while the output register is full and stalled
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_center <= wvb_pkg::SAT_CENTER_RESET;
    end else if (cfg_valid) begin
      sat_center <= cfg_data;
    end
  end

  // Stage 1: weights, products, table index
  logic [15:0] w_ref, w_tar;
  logic [16:0] s_w;
  logic [18:0] d2b;
  logic        v1;
  logic [31:0] p_ref1, p_tar1;
  logic [16:0] s_w1;
  logic [15:0] w_tar1;
  logic [SAT_TABLE_BITS-1:0] idx1;

  assign w_ref = 16'hFFFF - in_data.aff_ref;
  assign w_tar = 16'hFFFF - in_data.aff_tar;
  assign s_w   = {1'b0, w_ref} + {1'b0, w_tar};
  assign d2b   = {2'b00, s_w} + 19'd131072 - {2'b00, sat_center, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ref1 <= w_ref * in_data.ct_ref;
      p_tar1 <= w_tar * in_data.ct_tar;
      s_w1   <= s_w;
      w_tar1 <= w_tar;
      idx1   <= d2b[17 -: SAT_TABLE_BITS];
    end
  end

  // Divider pipeline; entry 0 is loaded from stage 1
  logic                 dv_v    [NSTEP+1];
  logic [16:0]          dv_s    [NSTEP+1];
  logic                 dv_zero [NSTEP+1];
  logic [FRAC_BITS-1:0] dv_sat  [NSTEP+1];
  logic [16:0]          dv_rb   [NSTEP+1];
  logic [15:0]          dv_qb   [NSTEP+1];
  logic [16:0]          dv_rh   [NSTEP+1];
  logic [HQ-1:0]        dv_qh   [NSTEP+1];
  logic [32:0]          num;

  assign num = {1'b0, p_ref1} + {1'b0, p_tar1};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_s[0]    <= s_w1;
      dv_zero[0] <= (s_w1 == 17'd0);
      dv_sat[0]  <= SAT_TAB[idx1];
      dv_rb[0]   <= num[32:16];
      dv_qb[0]   <= num[15:0];
      dv_rh[0]   <= {2'b00, w_tar1[15:1]};
      dv_qh[0]   <= {w_tar1[0], {(HQ-1){1'b0}}};
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    logic [17:0] tb, th;
    logic        geb, geh;
    logic [17:0] rb_sub, rh_sub;

    assign tb     = {dv_rb[k], dv_qb[k][15]};
    assign th     = {dv_rh[k], dv_qh[k][HQ-1]};
    assign geb    = tb >= {1'b0, dv_s[k]};
    assign geh    = th >= {1'b0, dv_s[k]};
    assign rb_sub = geb ? tb - {1'b0, dv_s[k]} : tb;
    assign rh_sub = geh ? th - {1'b0, dv_s[k]} : th;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    // Resolve one quotient bit of each division per stage, from its offset (BOFF, HOFF) on
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_s[k+1]    <= dv_s[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_sat[k+1]  <= dv_sat[k];
        if (k >= BOFF) begin
          dv_rb[k+1] <= rb_sub[16:0];
          dv_qb[k+1] <= {dv_qb[k][14:0], geb};
        end else begin
          dv_rb[k+1] <= dv_rb[k];
          dv_qb[k+1] <= dv_qb[k];
        end
        if (k >= HOFF) begin
          dv_rh[k+1] <= rh_sub[16:0];
          dv_qh[k+1] <= {dv_qh[k][HQ-2:0], geh};
        end else begin
          dv_rh[k+1] <= dv_rh[k];
          dv_qh[k+1] <= dv_qh[k];
        end
      end
    end
  end

  // Color stage 1: sector decode and saturation product
  logic [HQ-1:0]        h6;
  logic [2:0]           sec;
  logic [FRAC_BITS-1:0] fr;
  logic [FRAC_BITS:0]   mx;
  logic [2*FRAC_BITS:0] prod;
  logic                 c_v;
  logic [2:0]           c_sec;
  logic [FRAC_BITS-1:0] c_sat;
  logic [FRAC_BITS-1:0] c_prod;
  logic [15:0]          c_blend;

  assign h6  = dv_zero[NSTEP] ? '0 : dv_qh[NSTEP];
  assign sec = h6[HQ-1:FRAC_BITS];
  assign fr  = h6[FRAC_BITS-1:0];

  always_comb begin
    unique case (sec)
      SEC_YEL_GRN, SEC_CYN_BLU: mx = {1'b0, fr};
      default:                  mx = ONE - {1'b0, fr};
    endcase
  end

  assign prod = dv_sat[NSTEP] * mx;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= dv_v[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sec   <= sec;
      c_sat   <= dv_sat[NSTEP];
      c_prod  <= prod[2*FRAC_BITS-1:FRAC_BITS];
      c_blend <= dv_zero[NSTEP] ? 16'd0 : dv_qb[NSTEP];
    end
  end

  // Color stage 2: assemble components and scale to 8 bits
  logic [FRAC_BITS:0] mv, sv, rc, gc, bc;

  assign mv = ONE - {1'b0, c_prod};
  assign sv = ONE - {1'b0, c_sat};

  always_comb begin
    rc = ONE;
    gc = ONE;
    bc = ONE;
    unique case (c_sec)
      SEC_YEL_GRN: begin
        rc = mv;
        bc = sv;
      end
      SEC_GRN_CYN: begin
        rc = sv;
        bc = mv;
      end
      SEC_CYN_BLU: begin
        rc = sv;
        gc = mv;
      end
      SEC_BLU_MAG: begin
        rc = mv;
        gc = sv;
      end
      default: begin
        gc = mv;
        bc = sv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.blend_value <= c_blend;
      out_data.red         <= to_chan(rc);
      out_data.green       <= to_chan(gc);
      out_data.blue        <= to_chan(bc);
    end
  end

endmodule

/* test/weighted_volume_blend_colormap_unit_tb.sv */
`timescale 1ns / 100ps

module weighted_volume_blend_colormap_unit_tb;

  localparam int TBL_BITS = 8;
  localparam int FB = 16;
  localparam int PIPE_LAT = 24;
  localparam longint CYCLE_LIMIT = 400000;

  // Scoreboard: predicts each voxel's blend value and color and compares results in order
  class voxel_scoreboard;
    wvb_pkg::out_t pending[$];
    longint unsigned sat_lut[256];
    logic [15:0] center;
    int errors;

    function new();
      longint unsigned one;
      longint c;
      longint unsigned a;
      longint unsigned e;
      longint unsigned v;
      one = 64'd1 << FB;
      errors = 0;
      center = wvb_pkg::SAT_CENTER_RESET;
      for (int i = 0; i < 256; i++) begin
        c = longint'((i << (18 - TBL_BITS)) + (1 << (17 - TBL_BITS))) - 131072;
        a = (c < 0) ? -c : c;
        e = wvb_pkg::exp_neg_q31((a * wvb_pkg::K_Q31) >> 5);
        if (c >= 0) v = (one << 31) / (wvb_pkg::ONE_Q31 + e);
        else v = (one * e) / (wvb_pkg::ONE_Q31 + e);
        if (v > one - 1) v = one - 1;
        sat_lut[i] = v;
      end
    endfunction

    function void note_voxel(wvb_pkg::in_t x);
      longint unsigned one;
      longint unsigned wr;
      longint unsigned wt;
      longint unsigned sw;
      longint unsigned blend;
      longint unsigned h6;
      longint unsigned s;
      longint unsigned f;
      longint unsigned r;
      longint unsigned g;
      longint unsigned b;
      longint d2;
      wvb_pkg::out_t o;
      one = 64'd1 << FB;
      wr = 65535 - x.aff_ref;
      wt = 65535 - x.aff_tar;
      sw = wr + wt;
      blend = 0;
      h6 = 0;
      r = one;
      g = one;
      b = one;
      if (sw != 0) begin
        blend = (wr * x.ct_ref + wt * x.ct_tar) / sw;
        h6 = ((4 * wt) << FB) / sw;
      end
      d2 = longint'(sw) - 2 * longint'(center);
      s = sat_lut[((d2 + 131072) >> (18 - TBL_BITS)) & 255];
      f = h6 & (one - 1);
      case (h6 >> FB)
        1: begin
          r = one - ((s * f) >> FB);
          b = one - s;
        end
        2: begin
          r = one - s;
          b = one - ((s * (one - f)) >> FB);
        end
        3: begin
          r = one - s;
          g = one - ((s * f) >> FB);
        end
        4: begin
          r = one - ((s * (one - f)) >> FB);
          g = one - s;
        end
        default: begin
          g = one - ((s * (one - f)) >> FB);
          b = one - s;
        end
      endcase
      o.blend_value = blend[15:0];
      o.red = 8'((255 * r) >> FB);
      o.green = 8'((255 * g) >> FB);
      o.blue = 8'((255 * b) >> FB);
      pending = {pending, o};
    endfunction

    function void check_result(wvb_pkg::out_t got);
      wvb_pkg::out_t exp_o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.blend_value !== exp_o.blend_value) begin
        $display("%0t: blend_value exp %0d got %0d", $time, exp_o.blend_value, got.blend_value);
        errors++;
      end
      if (got.red !== exp_o.red) begin
        $display("%0t: red exp %0d got %0d", $time, exp_o.red, got.red);
        errors++;
      end
      if (got.green !== exp_o.green) begin
        $display("%0t: green exp %0d got %0d", $time, exp_o.green, got.green);
        errors++;
      end
      if (got.blue !== exp_o.blue) begin
        $display("%0t: blue exp %0d got %0d", $time, exp_o.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  wvb_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  wvb_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  voxel_scoreboard board;
  longint cycles;
  bit hold_off;
  bit sink_calm;

  weighted_volume_blend_colormap_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Cycle counter and timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("weighted_volume_blend_colormap_unit_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end

  // Drive receiver stall: random gaps, long hold-off on request
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if (sink_calm) begin
        out_stall <= 0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1;
          repeat (n - 1) @(posedge clk);
          @(posedge clk);
        end
        out_stall <= 0;
      end
    end
  end

  // Offer one voxel and hold it until accepted
  task automatic send_voxel(wvb_pkg::in_t v);
    in_valid <= 1;
    in_data <= v;
    do @(posedge clk); while (in_stall);
    board.note_voxel(v);
  endtask

  task automatic send_with_gap(wvb_pkg::in_t v);
    int n;
    n = pick_gap();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    send_voxel(v);
  endtask

  task automatic write_center(logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.center = v;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_aff();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'(65535 - $urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic wvb_pkg::in_t rand_voxel();
    wvb_pkg::in_t v;
    v.ct_ref = 16'($urandom);
    v.ct_tar = 16'($urandom);
    v.aff_ref = rand_aff();
    v.aff_tar = rand_aff();
    return v;
  endfunction

  initial begin
    logic [15:0] centers[6];
    board = new();
    hold_off = 0;
    sink_calm = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, zero weights, target-only weight, hue sectors
    send_voxel('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_voxel('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_voxel('{16'h1234, 16'hFFFF, 16'h4321, 16'hFFFF});
    send_voxel('{16'hABCD, 16'hFFFF, 16'h5555, 16'h0000});
    send_voxel('{16'hABCD, 16'h0000, 16'h5555, 16'hFFFF});
    send_voxel('{16'hFFFF, 16'hFFFE, 16'h0000, 16'hFFFF});
    for (int i = 0; i < 8; i++)
      send_voxel('{16'(i * 9000), 16'(i * 8000), 16'(65535 - i * 7000), 16'(60000 - i * 8000)});
    for (int i = 0; i < 6; i++)
      send_voxel('{16'h8000, 16'hFFFF - 16'(i * 3), 16'h7FFF, 16'hFFFF - 16'(i * 5)});

    // Random phases across several saturation centers, extremes included
    centers = '{16'd0, 16'hFFFF, 16'd12000, 16'd1, 16'd40000, 16'd30000};
    for (int p = 0; p < 6; p++) begin
      drain();
      write_center(p == 5 ? 16'($urandom) : centers[p]);
      for (int i = 0; i < 95; i++) begin
        if (p == 2 && i == 20) begin
          // Long receiver hold-off with the sender still offering
          hold_off = 1;
          for (int k = 0; k < 60; k++) send_voxel(rand_voxel());
        end
        if (p == 4 && i < 30) sink_calm = 1;
        else sink_calm = 0;
        send_with_gap(rand_voxel());
      end
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("weighted_volume_blend_colormap_unit_tb: PASS");
    end else begin
      $display("weighted_volume_blend_colormap_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
